// ===== rtl/rwgf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radius weighted grid filter package
// Shared types, sizes, codes and the distance table of the grid filter.
// ----------------------------------------------------------------------------
package rwgf_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int MAX_REACH = 3;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int DIM_W     = 7;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int DEPTH     = MAX_ROWS * MAX_COLS;
    localparam int VALUE_W   = 32;
    localparam int RAD_W     = 10;
    localparam int DIST_W    = 11;
    localparam int REACH_W   = 2;
    localparam int SQ_W      = 5;
    localparam int PROD_W    = VALUE_W + RAD_W + 1;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 16;
    localparam int DIV_CYCLES = NUM_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Q8 = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [DIM_W-1:0] GRID_COLS_RST = 7'd64;
    localparam logic [DIM_W-1:0] GRID_ROWS_RST = 7'd64;
    localparam logic [RAD_W-1:0] RADIUS_RST    = 10'd384;

    typedef struct packed {
        logic                      opcode;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } rwgf_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] filtered_value;
        logic                      status;
    } rwgf_out_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    // Euclidean distance in 1/256 units, rounded to nearest, by squared offset.
    function automatic logic [DIST_W-1:0] dist_q8(input logic [SQ_W-1:0] n);
        logic [DIST_W-1:0] d;
        case (n)
            5'd0:    d = 11'd0;
            5'd1:    d = 11'd256;
            5'd2:    d = 11'd362;
            5'd4:    d = 11'd512;
            5'd5:    d = 11'd572;
            5'd8:    d = 11'd724;
            5'd9:    d = 11'd768;
            5'd10:   d = 11'd810;
            5'd13:   d = 11'd923;
            5'd18:   d = 11'd1086;
            default: d = 11'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/rwgf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module rwgf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rwgf_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radius weighted grid filter divider
// Restoring unsigned division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rwgf_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  rwgf_pkg::div_req_t req,
    output rwgf_pkg::div_rsp_t rsp
);

    import rwgf_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [NUM_W-1:0]     quo_reg;
    logic [NUM_W-1:0]     quo_next;

    always_comb
    begin
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] rem_v;
        logic [NUM_W-1:0] quo_v;
        rem_v = rem_reg;
        quo_v = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            t     = {rem_v, quo_v[NUM_W-1]};
            quo_v = {quo_v[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg})
            begin
                t        = t - {1'b0, den_reg};
                quo_v[0] = 1'b1;
            end
            rem_v = t[DEN_W-1:0];
        end
        rem_next = rem_v;
        quo_next = quo_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_CYCLES - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/radius_weighted_grid_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radius weighted grid filter
// A write or error beat passes through the done state into the output register,
// and the next beat can be accepted in the cycle that beat appears. A query scans
// its window one cell per cycle through the single memory port, then drains its
// pipeline and divides. One item is processed at a time; reset restores the
// control and configuration registers, not the store.
// ----------------------------------------------------------------------------
module radius_weighted_grid_filter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rwgf_pkg::rwgf_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rwgf_pkg::rwgf_out_t                 out_data,
    input  logic                                cfg_we,
    input  logic [rwgf_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [rwgf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import rwgf_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0] grid_cols_reg;
    logic [DIM_W-1:0] grid_rows_reg;
    logic [RAD_W-1:0] radius_reg;

    logic [DIM_W-1:0]   cols;
    logic [DIM_W-1:0]   rows;
    logic [RAD_W-1:0]   rad;
    logic [REACH_W-1:0] reach;
    logic               in_range;
    logic               accept;
    logic [ROW_W-1:0]   r0;
    logic [ROW_W-1:0]   r1;
    logic [COL_W-1:0]   c0;
    logic [COL_W-1:0]   c1;
    logic [DIM_W-1:0]   r_hi;
    logic [DIM_W-1:0]   c_hi;

    logic [ROW_W-1:0] qrow_reg;
    logic [COL_W-1:0] qcol_reg;
    logic [ROW_W-1:0] r1_reg;
    logic [COL_W-1:0] c0_reg;
    logic [COL_W-1:0] c1_reg;
    logic [ROW_W-1:0] k_reg;
    logic [COL_W-1:0] l_reg;
    logic             scan_last;

    logic [ROW_W-1:0]   dr_full;
    logic [COL_W-1:0]   dc_full;
    logic [REACH_W-1:0] dr;
    logic [REACH_W-1:0] dc;
    logic [SQ_W-1:0]    sq;
    logic [DIST_W-1:0]  dist_val;
    logic [RAD_W-1:0]   weight;

    logic                      p1_reg;
    logic                      p2_reg;
    logic [RAD_W-1:0]          w1_reg;
    logic [RAD_W-1:0]          w2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]          den_reg;
    logic                      neg_reg;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [VALUE_W-1:0]    mem_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                      drain_empty;
    logic                      load_out;
    logic                      out_free;
    logic signed [VALUE_W-1:0] sat_value;
    rwgf_out_t                 res_reg;
    rwgf_out_t                 out_reg;
    logic                      out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= GRID_COLS_RST;
            grid_rows_reg <= GRID_ROWS_RST;
            radius_reg    <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_GRID_COLS: grid_cols_reg <= cfg_wdata[DIM_W-1:0];
                CFG_GRID_ROWS: grid_rows_reg <= cfg_wdata[DIM_W-1:0];
                CFG_RADIUS_Q8: radius_reg    <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (grid_cols_reg == '0)
            cols = DIM_W'(1);
        else if (grid_cols_reg > DIM_W'(MAX_COLS))
            cols = DIM_W'(MAX_COLS);
        else
            cols = grid_cols_reg;
        if (grid_rows_reg == '0)
            rows = DIM_W'(1);
        else if (grid_rows_reg > DIM_W'(MAX_ROWS))
            rows = DIM_W'(MAX_ROWS);
        else
            rows = grid_rows_reg;
        rad = (radius_reg == '0) ? RAD_W'(1) : radius_reg;
        if (rad[RAD_W-1:8] > REACH_W'(MAX_REACH))
            reach = REACH_W'(MAX_REACH);
        else
            reach = rad[RAD_W-1:8];
    end

    assign accept   = in_valid && in_ready;
    assign in_range = ({1'b0, in_data.row} < rows) && ({1'b0, in_data.col} < cols);

    always_comb
    begin
        r0   = (in_data.row >= ROW_W'(reach)) ? in_data.row - ROW_W'(reach) : '0;
        c0   = (in_data.col >= COL_W'(reach)) ? in_data.col - COL_W'(reach) : '0;
        r_hi = {1'b0, in_data.row} + DIM_W'(reach);
        c_hi = {1'b0, in_data.col} + DIM_W'(reach);
        r1   = (r_hi < rows - 1'b1) ? r_hi[ROW_W-1:0] : ROW_W'(rows - 1'b1);
        c1   = (c_hi < cols - 1'b1) ? c_hi[COL_W-1:0] : COL_W'(cols - 1'b1);
    end

    assign scan_last = (k_reg == r1_reg) && (l_reg == c1_reg);

    always_comb
    begin
        dr_full  = (k_reg > qrow_reg) ? k_reg - qrow_reg : qrow_reg - k_reg;
        dc_full  = (l_reg > qcol_reg) ? l_reg - qcol_reg : qcol_reg - l_reg;
        dr       = dr_full[REACH_W-1:0];
        dc       = dc_full[REACH_W-1:0];
        sq       = SQ_W'(dr) * SQ_W'(dr) + SQ_W'(dc) * SQ_W'(dc);
        dist_val = dist_q8(sq);
        weight   = (dist_val <= {1'b0, rad}) ? RAD_W'({1'b0, rad} - dist_val) : '0;
    end

    assign drain_empty = !p1_reg && !p2_reg;
    assign out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_range || in_data.opcode == OP_WRITE)
                        state_next = ST_DONE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (drain_empty)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        mem_we   = accept && in_range && (in_data.opcode == OP_WRITE);
        if (state_reg == ST_SCAN)
            mem_addr = {k_reg, l_reg};
        else
            mem_addr = {in_data.row, in_data.col};
        div_req.start    = (state_reg == ST_DRAIN) && drain_empty;
        div_req.dividend = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        div_req.divisor  = den_reg;
        load_out = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p1_reg    <= (state_reg == ST_SCAN);
            p2_reg    <= p1_reg;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qrow_reg       <= in_data.row;
            qcol_reg       <= in_data.col;
            r1_reg         <= r1;
            c0_reg         <= c0;
            c1_reg         <= c1;
            k_reg          <= r0;
            l_reg          <= c0;
            num_reg        <= '0;
            den_reg        <= '0;
            res_reg.status <= in_range ? STATUS_OK : STATUS_RANGE;
            res_reg.filtered_value <= '0;
        end
        else
        begin
            if (state_reg == ST_SCAN)
            begin
                if (l_reg == c1_reg)
                begin
                    l_reg <= c0_reg;
                    k_reg <= k_reg + 1'b1;
                end
                else
                begin
                    l_reg <= l_reg + 1'b1;
                end
            end
            if (p2_reg)
            begin
                num_reg <= num_reg + NUM_W'(prod_reg);
                den_reg <= den_reg + DEN_W'(w2_reg);
            end
            if (state_reg == ST_DIVIDE && div_rsp.done)
                res_reg.filtered_value <= sat_value;
        end
        w1_reg   <= weight;
        w2_reg   <= w1_reg;
        prod_reg <= $signed({1'b0, w1_reg}) * $signed(mem_rdata);
        if (div_req.start)
            neg_reg <= num_reg[NUM_W-1];
        if (load_out)
            out_reg <= res_reg;
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            if (div_rsp.quotient > NUM_W'(32'h7FFF_FFFF))
                sat_value = 32'sh7FFF_FFFF;
            else
                sat_value = $signed(div_rsp.quotient[VALUE_W-1:0]);
        end
        else
        begin
            if (div_rsp.quotient > NUM_W'(32'h8000_0000))
                sat_value = 32'sh8000_0000;
            else
                sat_value = $signed(-div_rsp.quotient[VALUE_W-1:0]);
        end
    end

    rwgf_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(in_data.value),
        .rdata(mem_rdata)
    );

    rwgf_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/rwgf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radius weighted grid filter checker
// Port level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
module rwgf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input rwgf_pkg::rwgf_in_t              in_data,
    input logic                            out_valid,
    input logic                            out_ready,
    input rwgf_pkg::rwgf_out_t             out_data,
    input logic                            cfg_we,
    input logic [rwgf_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input logic [rwgf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import rwgf_pkg::*;

    // A result beat that is held back keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("held result beat changed");

    // An address error never carries a filtered value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == STATUS_RANGE) |-> out_data.filtered_value == '0)
        else $error("error result with nonzero value");

    // Only one item is in flight, so an accepted beat closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // A new result appears only at the end of processing, never from idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result produced without an accepted item");

endmodule

bind radius_weighted_grid_filter_top rwgf_checker u_rwgf_checker (.*);
